// File: rtl/core/ddo_pkg.sv
// Package for the differential-drive odometry core.
// Types, sequencer states, fixed-point constants and the CORDIC arc table.
// No dependencies.
`default_nettype none

package ddo_pkg;

    localparam int CORDIC_STEPS = 15;
    localparam int STEP_W       = 4;
    localparam int CW           = 18;   // CORDIC x/y datapath width

    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 18'sd9949;
    localparam logic signed [15:0]   UNIT_Q14        = 16'sd16384;
    localparam logic [29:0]          BAM_PER_RAD     = 30'd683565276;
    localparam logic [15:0]          IWB_RESET       = 16'd512;

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_TICK = 2'd1,
        ACT_CLR  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORD,
        ST_MUL_XC,
        ST_MUL_XD,
        ST_RND_X,
        ST_ADD_X,
        ST_MUL_YS,
        ST_MUL_YD,
        ST_RND_Y,
        ST_ADD_Y,
        ST_MUL_HM,
        ST_MUL_HD,
        ST_MUL_HL,
        ST_MUL_HH,
        ST_ADD_H,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               done;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } t_cordic_res;

    // arc of each CORDIC step in binary-angle units
    function automatic logic [13:0] arc_bam(input logic [STEP_W-1:0] idx);
        logic [13:0] a;
        case (idx)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            4'd14:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ddo_cordic.sv
// Iterative CORDIC for cos/sin of a binary angle, one rotation step per cycle.
// Quadrant reduction on load, clamp and quadrant fold on the result.
// Depends on ddo_pkg.
`default_nettype none

module ddo_cordic import ddo_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_angle,
    output t_cordic_res      o_res
);

    localparam logic signed [CW-1:0] UNIT_W = {{(CW-16){1'b0}}, UNIT_Q14};

    logic                    r_busy;
    logic                    r_fin;
    logic [STEP_W-1:0]       r_cnt;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [15:0]      r_z;
    logic [1:0]              r_quad;

    logic [15:0]             shifted;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [15:0]      arc;
    logic signed [CW-1:0]    n_x;
    logic signed [CW-1:0]    n_y;
    logic signed [15:0]      n_z;
    logic signed [15:0]      xc;
    logic signed [15:0]      yc;

    function automatic logic signed [15:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [15:0] r;
        if (v > UNIT_W) begin
            r = UNIT_Q14;
        end else if (v < -UNIT_W) begin
            r = -UNIT_Q14;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb begin
        shifted = i_angle + 16'd8192;
        xs      = r_x >>> r_cnt;
        ys      = r_y >>> r_cnt;
        arc     = {2'b00, arc_bam(r_cnt)};
        if (!r_z[15]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - arc;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + arc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN_INV;
            r_y    <= '0;
            r_z    <= signed'({2'b00, shifted[13:0]}) - 16'sd8192;
            r_quad <= shifted[15:14];
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_comb begin
        xc         = clamp_unit(r_x);
        yc         = clamp_unit(r_y);
        o_res.done = r_fin;
        case (r_quad)
            2'd0: begin
                o_res.cos_v = xc;
                o_res.sin_v = yc;
            end
            2'd1: begin
                o_res.cos_v = -yc;
                o_res.sin_v = xc;
            end
            2'd2: begin
                o_res.cos_v = -xc;
                o_res.sin_v = -yc;
            end
            default: begin
                o_res.cos_v = yc;
                o_res.sin_v = -xc;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/diff_drive_odometry.sv
// Differential-drive dead-reckoning odometry: one shared 33x31 multiplier
// under a sequencer, fed by an iterative CORDIC. Depends on ddo_pkg, ddo_cordic.
// Sequence: a tick word runs the 15 CORDIC steps, one hand-off step, the 13
// multiply/round/add steps and the output load, which waits while the last
// result is held; set-speeds and clear apply in the cycle after acceptance.
// Ticks do not overlap, as the CORDIC loop and the multiplier are shared;
// input stays blocked while a tick is in flight.
// Reset (synchronous, active low) clears pose, speeds and handshakes; the
// wheel-base register returns to 512.
`default_nettype none

module diff_drive_odometry import ddo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_left_speed_in,
    input  wire logic signed [15:0] i_right_speed_in,
    input  wire logic [15:0]        i_time_step,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic [15:0]             o_heading,
    output logic signed [15:0]      o_left_speed_out,
    output logic signed [15:0]      o_right_speed_out
);

    t_state              r_state;
    t_state              n_state;

    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic [15:0]         r_head;
    logic signed [15:0]  r_left;
    logic signed [15:0]  r_right;
    logic [15:0]         r_iwb;

    logic [15:0]         r_dt;
    logic signed [16:0]  r_sum;
    logic [15:0]         r_mag;
    logic                r_neg;
    logic signed [63:0]  r_p;
    logic signed [26:0]  r_rnd;
    logic [29:0]         r_t;

    logic                r_out_valid;
    logic signed [31:0]  r_ox;
    logic signed [31:0]  r_oy;
    logic [15:0]         r_ohead;
    logic signed [15:0]  r_ol;
    logic signed [15:0]  r_or;

    logic                in_acc;
    logic                out_load;
    logic                cstart;
    t_cordic_res         cres;

    logic signed [32:0]  mul_a;
    logic signed [30:0]  mul_b;
    logic signed [63:0]  mul_p;

    logic signed [16:0]  diff;
    logic signed [49:0]  rnd_in;
    logic signed [31:0]  acc_base;
    logic signed [32:0]  acc;
    logic signed [31:0]  acc_sat;
    logic [39:0]         hsum;
    logic [15:0]         dh;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cstart   = in_acc && (i_action == ACT_TICK);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cstart),
        .i_angle (r_head),
        .o_res   (cres)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        n_state    = r_state;
        case (r_state)
            ST_IDLE:   if (cstart) n_state = ST_CORD;
            ST_CORD:   if (cres.done) n_state = ST_MUL_XC;
            ST_MUL_XC: n_state = ST_MUL_XD;
            ST_MUL_XD: n_state = ST_RND_X;
            ST_RND_X:  n_state = ST_ADD_X;
            ST_ADD_X:  n_state = ST_MUL_YS;
            ST_MUL_YS: n_state = ST_MUL_YD;
            ST_MUL_YD: n_state = ST_RND_Y;
            ST_RND_Y:  n_state = ST_ADD_Y;
            ST_ADD_Y:  n_state = ST_MUL_HM;
            ST_MUL_HM: n_state = ST_MUL_HD;
            ST_MUL_HD: n_state = ST_MUL_HL;
            ST_MUL_HL: n_state = ST_MUL_HH;
            ST_MUL_HH: n_state = ST_ADD_H;
            ST_ADD_H:  n_state = ST_OUT;
            ST_OUT:    if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_MUL_XC: begin
                mul_a = {{16{r_sum[16]}}, r_sum};
                mul_b = {{15{cres.cos_v[15]}}, cres.cos_v};
            end
            ST_MUL_YS: begin
                mul_a = {{16{r_sum[16]}}, r_sum};
                mul_b = {{15{cres.sin_v[15]}}, cres.sin_v};
            end
            ST_MUL_XD, ST_MUL_YD: begin
                mul_a = r_p[32:0];
                mul_b = {15'd0, r_dt};
            end
            ST_MUL_HM: begin
                mul_a = {17'd0, r_mag};
                mul_b = {15'd0, r_iwb};
            end
            ST_MUL_HD: begin
                mul_a = {1'b0, r_p[31:0]};
                mul_b = {15'd0, r_dt};
            end
            ST_MUL_HL: begin
                mul_a = {9'd0, r_p[23:0]};
                mul_b = {1'b0, BAM_PER_RAD};
            end
            ST_MUL_HH: begin
                mul_a = {9'd0, r_p[47:24]};
                mul_b = {1'b0, BAM_PER_RAD};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        diff     = {r_right[15], r_right} - {r_left[15], r_left};
        // half away from zero: bias one less for negative products
        rnd_in   = r_p[49:0] + 50'sd4194304 - {49'd0, r_p[49]};
        acc_base = (r_state == ST_ADD_X) ? r_x : r_y;
        acc      = {acc_base[31], acc_base} + {{6{r_rnd[26]}}, r_rnd};
        if (acc[32] != acc[31]) begin
            acc_sat = acc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            acc_sat = acc[31:0];
        end
        hsum = r_p[39:0] + {10'd0, r_t} + 40'h80_0000;
        dh   = r_neg ? (16'd0 - hsum[39:24]) : hsum[39:24];
    end

    // pose and speed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_head  <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else begin
            if (in_acc && (i_action == ACT_SET)) begin
                r_left  <= i_left_speed_in;
                r_right <= i_right_speed_in;
            end
            if (in_acc && (i_action == ACT_CLR)) begin
                r_x     <= '0;
                r_y     <= '0;
                r_head  <= '0;
                r_left  <= '0;
                r_right <= '0;
            end
            if (r_state == ST_ADD_X) r_x <= acc_sat;
            if (r_state == ST_ADD_Y) r_y <= acc_sat;
            if (r_state == ST_ADD_H) r_head <= r_head + dh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iwb <= IWB_RESET;
        end else if (i_cfg_we) begin
            r_iwb <= i_cfg_data;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (cstart) begin
            r_dt  <= i_time_step;
            r_sum <= {r_left[15], r_left} + {r_right[15], r_right};
            r_mag <= diff[16] ? 16'(-diff) : diff[15:0];
            r_neg <= diff[16];
        end
        case (r_state)
            ST_MUL_XC, ST_MUL_XD, ST_MUL_YS, ST_MUL_YD,
            ST_MUL_HM, ST_MUL_HD, ST_MUL_HH: r_p <= mul_p;
            ST_MUL_HL: r_t <= mul_p[53:24];
            ST_RND_X, ST_RND_Y: r_rnd <= rnd_in[49:23];
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_ohead <= r_head;
            r_ol    <= r_left;
            r_or    <= r_right;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pos_x           = r_ox;
    assign o_pos_y           = r_oy;
    assign o_heading         = r_ohead;
    assign o_left_speed_out  = r_ol;
    assign o_right_speed_out = r_or;

    a_clear_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_action == ACT_CLR) |=>
            r_x == 32'sd0 && r_y == 32'sd0 && r_head == 16'd0 &&
            r_left == 16'sd0 && r_right == 16'sd0)
        else $error("clear word left pose or speeds set");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cres.done |-> r_state == ST_CORD)
        else $error("CORDIC finished outside its wait state");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result word raised outside the output step");

endmodule

`default_nettype wire
